// ===== hdl/fltw_pkg.sv =====
// ----------------------------------------------------------------------------
// fltw_pkg
// Types, codes and helpers shared by the four-level page table walker.
// ----------------------------------------------------------------------------
`default_nettype none

package fltw_pkg;

  localparam int VA_W    = 64;
  localparam int HVA_W   = 48;
  localparam int PA_W    = 52;
  localparam int ENTRY_W = 64;
  localparam int PAB_W   = 6;
  localparam int LVL_W   = 3;

  localparam logic [PAB_W-1:0] PAB_MIN   = 6'd36;
  localparam logic [PAB_W-1:0] PAB_MAX   = 6'd52;
  localparam logic [PAB_W-1:0] PAB_RESET = 6'd52;

  localparam logic [16:0] HIGH_ALL_ONE = 17'h1ffff;

  // result kinds
  localparam logic RK_READ = 1'b0;
  localparam logic RK_DONE = 1'b1;

  // input kinds
  localparam logic IK_REQUEST  = 1'b0;
  localparam logic IK_RESPONSE = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FAULT     = 2'd1;
  localparam logic [1:0] ST_IDLE_RESP = 2'd2;

  // entry bits
  localparam int B_PRESENT = 0;
  localparam int B_WRITE   = 1;
  localparam int B_USER    = 2;
  localparam int B_LARGE   = 7;
  localparam int B_NX      = 63;

  localparam logic [LVL_W-1:0] LVL_NONE = 3'd0;
  localparam logic [LVL_W-1:0] LVL_1    = 3'd1;
  localparam logic [LVL_W-1:0] LVL_2    = 3'd2;
  localparam logic [LVL_W-1:0] LVL_3    = 3'd3;
  localparam logic [LVL_W-1:0] LVL_4    = 3'd4;

  typedef struct packed {
    logic                kind;
    logic [VA_W-1:0]     virt_addr;
    logic [PA_W-1:0]     root_table;
    logic [ENTRY_W-1:0]  read_data;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic [PA_W-1:0]  read_addr;
    logic [1:0]       status;
    logic [PA_W-1:0]  phys_addr;
    logic             perm_user;
    logic             perm_write;
    logic             no_exec;
    logic [1:0]       page_size;
  } out_item_t;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_FAULT      = 2'd0,
    OP_WALK_START = 2'd1,
    OP_ENTRY      = 2'd2
  } op_code_t;

  typedef struct packed {
    op_code_t            code;
    logic [HVA_W-1:0]    va;
    logic [ENTRY_W-1:0]  data;  // first read address on a start, entry on a response
  } op_t;

  // 9-bit table index of a virtual address at a given level
  function automatic logic [8:0] table_index(input logic [HVA_W-1:0] va,
                                             input logic [LVL_W-1:0] lvl);
    logic [8:0] idx;
    case (lvl)
      LVL_1:   idx = va[20:12];
      LVL_2:   idx = va[29:21];
      LVL_3:   idx = va[38:30];
      LVL_4:   idx = va[47:39];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/fltw_front.sv =====
// ----------------------------------------------------------------------------
// fltw_front
// Classifies each incoming item: canonical and root checks on requests,
// first table entry address, or pass-through of an entry response.
// ----------------------------------------------------------------------------
`default_nettype none

module fltw_front (
  input  var fltw_pkg::in_item_t item,
  output var fltw_pkg::op_t      op
);

  logic [16:0]               high_bits;
  logic                      canonical;
  logic                      root_ok;
  logic [fltw_pkg::PA_W-1:0] first_addr;

  assign high_bits = item.virt_addr[63:47];
  assign canonical = (high_bits == 17'd0) || (high_bits == fltw_pkg::HIGH_ALL_ONE);
  assign root_ok   = (item.root_table != '0);

  // root plus index times 8, wrapping within the physical address width
  assign first_addr = item.root_table
                    + {40'd0,
                       fltw_pkg::table_index(item.virt_addr[47:0], fltw_pkg::LVL_4),
                       3'b000};

  always_comb begin
    op.va   = item.virt_addr[47:0];
    op.data = item.read_data;
    if (item.kind == fltw_pkg::IK_RESPONSE) begin
      op.code = fltw_pkg::OP_ENTRY;
    end else if (canonical && root_ok) begin
      op.code = fltw_pkg::OP_WALK_START;
      op.data = {12'd0, first_addr};
    end else begin
      op.code = fltw_pkg::OP_FAULT;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fltw_queue.sv =====
// ----------------------------------------------------------------------------
// fltw_queue
// Small first-in first-out queue of classified operations between the
// front and the back of the walker.
// ----------------------------------------------------------------------------
`default_nettype none

module fltw_queue #(
  parameter int DEPTH = 4
) (
  input  var logic          clk,
  input  var logic          rst,
  input  var logic          wr_en,
  input  var fltw_pkg::op_t wr_op,
  output var logic          full,
  input  var logic          rd_en,
  output var logic          rd_valid,
  output var fltw_pkg::op_t rd_op
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  fltw_pkg::op_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_op    = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fltw_back.sv =====
// ----------------------------------------------------------------------------
// fltw_back
// Walk engine: holds walk state, address width register and result for the consumer,
// carrying out one queued operation per cycle while no result waits or it is popped.
// ----------------------------------------------------------------------------
`default_nettype none

module fltw_back (
  input  var logic                         clk,
  input  var logic                         rst,
  input  var logic                         cfg_we,
  input  var logic [fltw_pkg::PAB_W-1:0]   cfg_data,
  input  var logic                         op_valid,
  input  var fltw_pkg::op_t                op,
  output var logic                         op_take,
  output var logic                         empty,
  input  var logic                         pop,
  output var fltw_pkg::out_item_t          result
);

  logic [fltw_pkg::PAB_W-1:0] phys_addr_bits;
  logic                       walk_busy;
  logic [fltw_pkg::LVL_W-1:0] walk_level;
  logic [fltw_pkg::HVA_W-1:0] held_virt_addr;
  logic [1:0]                 allow_bits;
  logic                       nx_seen;
  logic                       out_valid;

  logic                       walk_busy_next;
  logic [fltw_pkg::LVL_W-1:0] walk_level_next;
  logic [fltw_pkg::HVA_W-1:0] held_virt_addr_next;
  logic [1:0]                 allow_bits_next;
  logic                       nx_seen_next;
  fltw_pkg::out_item_t        res;

  logic [fltw_pkg::PAB_W-1:0] width_eff;
  logic [fltw_pkg::PA_W-1:0]  frame_mask;
  logic [fltw_pkg::PA_W-1:0]  frame;
  logic [fltw_pkg::PA_W-1:0]  off_mask;
  logic [fltw_pkg::LVL_W-1:0] lvl;
  logic [fltw_pkg::LVL_W-1:0] lvl_down;
  logic                       leaf;
  logic [1:0]                 allow_upd;

  assign empty   = !out_valid;
  assign op_take = op_valid && (!out_valid || pop);

  always_comb begin
    if (phys_addr_bits < fltw_pkg::PAB_MIN) begin
      width_eff = fltw_pkg::PAB_MIN;
    end else if (phys_addr_bits > fltw_pkg::PAB_MAX) begin
      width_eff = fltw_pkg::PAB_MAX;
    end else begin
      width_eff = phys_addr_bits;
    end
    for (int i = 0; i < fltw_pkg::PA_W; i++) begin
      frame_mask[i] = (i >= 12) && (fltw_pkg::PAB_W'(i) < width_eff);
    end
  end

  assign frame = op.data[fltw_pkg::PA_W-1:0] & frame_mask;

  // a corrupted level reads as level 1
  assign lvl = ((walk_level == fltw_pkg::LVL_NONE) || (walk_level > fltw_pkg::LVL_4))
             ? fltw_pkg::LVL_1 : walk_level;
  assign lvl_down = lvl - 1'b1;

  always_comb begin
    case (lvl)
      fltw_pkg::LVL_2: off_mask = {31'd0, 21'h1fffff};
      fltw_pkg::LVL_3: off_mask = {22'd0, 30'h3fffffff};
      default:         off_mask = {40'd0, 12'hfff};
    endcase
  end

  assign leaf = (lvl == fltw_pkg::LVL_1)
             || (((lvl == fltw_pkg::LVL_2) || (lvl == fltw_pkg::LVL_3))
                 && op.data[fltw_pkg::B_LARGE]);
  assign allow_upd = allow_bits & {op.data[fltw_pkg::B_USER], op.data[fltw_pkg::B_WRITE]};

  always_comb begin
    walk_busy_next      = walk_busy;
    walk_level_next     = walk_level;
    held_virt_addr_next = held_virt_addr;
    allow_bits_next     = allow_bits;
    nx_seen_next        = nx_seen;
    res                 = '0;
    res.result_kind     = fltw_pkg::RK_DONE;
    res.status          = fltw_pkg::ST_FAULT;
    case (op.code)
      fltw_pkg::OP_WALK_START: begin
        walk_busy_next      = 1'b1;
        walk_level_next     = fltw_pkg::LVL_4;
        held_virt_addr_next = op.va;
        allow_bits_next     = 2'b11;
        nx_seen_next        = 1'b0;
        res.result_kind     = fltw_pkg::RK_READ;
        res.status          = fltw_pkg::ST_OK;
        res.read_addr       = op.data[fltw_pkg::PA_W-1:0];
      end
      fltw_pkg::OP_ENTRY: begin
        if (!walk_busy) begin
          res.status = fltw_pkg::ST_IDLE_RESP;
        end else if (!op.data[fltw_pkg::B_PRESENT]) begin
          walk_busy_next  = 1'b0;
          walk_level_next = fltw_pkg::LVL_NONE;
        end else begin
          allow_bits_next = allow_upd;
          nx_seen_next    = nx_seen | op.data[fltw_pkg::B_NX];
          if (leaf) begin
            walk_busy_next  = 1'b0;
            walk_level_next = fltw_pkg::LVL_NONE;
            res.status      = fltw_pkg::ST_OK;
            res.phys_addr   = (frame & ~off_mask)
                            | ({4'd0, held_virt_addr} & off_mask);
            res.perm_user   = allow_upd[1];
            res.perm_write  = allow_upd[0];
            res.no_exec     = nx_seen | op.data[fltw_pkg::B_NX];
            res.page_size   = lvl_down[1:0];
          end else begin
            walk_level_next = lvl_down;
            res.result_kind = fltw_pkg::RK_READ;
            res.status      = fltw_pkg::ST_OK;
            // table frame is 4 KiB aligned, so the index simply fills the low bits
            res.read_addr   = {frame[fltw_pkg::PA_W-1:12],
                               fltw_pkg::table_index(held_virt_addr, lvl_down),
                               3'b000};
          end
        end
      end
      default: begin
        walk_busy_next  = 1'b0;
        walk_level_next = fltw_pkg::LVL_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phys_addr_bits <= fltw_pkg::PAB_RESET;
      walk_busy      <= 1'b0;
      walk_level     <= fltw_pkg::LVL_NONE;
      held_virt_addr <= '0;
      allow_bits     <= '0;
      nx_seen        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        phys_addr_bits <= cfg_data;
      end
      if (op_take) begin
        walk_busy      <= walk_busy_next;
        walk_level     <= walk_level_next;
        held_virt_addr <= held_virt_addr_next;
        allow_bits     <= allow_bits_next;
        nx_seen        <= nx_seen_next;
        out_valid      <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_take) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/four_level_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level page table walker with queue-style request and result ports.
// ----------------------------------------------------------------------------
// One item (translate request or table entry response) is accepted per clock
// cycle while full is low, and each gives exactly one result. An item passes
// through the classifier into an operation queue of QUEUE_DEPTH entries at the
// edge that accepts it; the walk engine retires one queued operation per cycle
// while its result register is empty or being popped, and registers the result
// there as it takes the operation. The queue and the single result register
// together absorb QUEUE_DEPTH + 1 items while pop stays low; full rises only
// when both are occupied. The address width register takes a write in every
// cycle (cfg_ready is high).
`default_nettype none

module four_level_page_table_walker #(
  parameter int QUEUE_DEPTH = 4
) (
  input  var logic                        clk,
  input  var logic                        rst,
  input  var logic                        push,
  output var logic                        full,
  input  var fltw_pkg::in_item_t          item,
  output var logic                        empty,
  input  var logic                        pop,
  output var fltw_pkg::out_item_t         result,
  input  var logic                        cfg_valid,
  output var logic                        cfg_ready,
  input  var logic [fltw_pkg::PAB_W-1:0]  cfg_data
);

  fltw_pkg::op_t front_op;
  fltw_pkg::op_t head_op;
  logic          head_valid;
  logic          head_take;

  assign cfg_ready = 1'b1;

  fltw_front u_front (
    .item (item),
    .op   (front_op)
  );

  fltw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_op    (front_op),
    .full     (full),
    .rd_en    (head_take),
    .rd_valid (head_valid),
    .rd_op    (head_op)
  );

  fltw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .op_valid (head_valid),
    .op       (head_op),
    .op_take  (head_take),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

`default_nettype wire

// ===== hdl/fltw_checker.sv =====
// ----------------------------------------------------------------------------
// fltw_checker
// Port-level checks for the page table walker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fltw_checker (
  input var logic                clk,
  input var logic                rst,
  input var logic                full,
  input var logic                empty,
  input var logic                pop,
  input var fltw_pkg::out_item_t result
);

  // reset leaves no result waiting and room for input
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queue state not cleared by reset");

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed while waiting");

  // a read request is always ok and carries no translation
  a_read_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.result_kind == fltw_pkg::RK_READ) |->
      (result.status == fltw_pkg::ST_OK && result.phys_addr == '0
       && result.page_size == 2'd0))
    else $error("read request with walk result fields");

  // a failed transaction reports nothing besides its status
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status != fltw_pkg::ST_OK) |->
      (result.result_kind == fltw_pkg::RK_DONE && result.read_addr == '0
       && result.phys_addr == '0 && !result.perm_user && !result.perm_write
       && !result.no_exec && result.page_size == 2'd0))
    else $error("failed result carries data");

  // page size never takes the unused code, status never the unused code
  a_codes: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.page_size != 2'd3 && result.status != 2'd3))
    else $error("unused code on result");

endmodule

bind four_level_page_table_walker fltw_checker u_fltw_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-level page table walker. Directed and
// random translate requests and entry responses go in through the push side;
// every accepted transaction is run through a local walk predictor and the
// popped results are compared field by field. Several address widths and
// idle/stall mixes are covered, one per phase.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 225;
  localparam int PHASE_COUNT  = 8;
  localparam int SETTLE_LEN   = 8;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          push = 1'b0;
  logic                          full;
  fltw_pkg::in_item_t            item = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  fltw_pkg::out_item_t           result;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [fltw_pkg::PAB_W-1:0]    cfg_data = '0;

  four_level_page_table_walker u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fltw_pkg::in_item_t          walk_items[$];
  fltw_pkg::out_item_t         expected_walk_results[$];
  fltw_pkg::out_item_t         want;
  int                          error_count = 0;
  int                          cycle_count = 0;
  int                          queued_count = 0;
  int                          send_idle_pct = 0;
  int                          recv_stall_pct = 0;

  // walker state as predicted
  logic [fltw_pkg::PAB_W-1:0]  width_reg = fltw_pkg::PAB_RESET;
  logic                        pred_active = 1'b0;
  logic [fltw_pkg::LVL_W-1:0]  pred_level = fltw_pkg::LVL_NONE;
  logic [fltw_pkg::HVA_W-1:0]  pred_va = '0;
  logic [1:0]                  pred_perm = '0;
  logic                        pred_nx = 1'b0;

  function automatic logic [fltw_pkg::PA_W-1:0] pte_address(
      input logic [fltw_pkg::PA_W-1:0] base,
      input logic [fltw_pkg::LVL_W-1:0] lvl);
    logic [63:0] idx;
    idx = ({16'd0, pred_va} >> (12 + 9 * (int'(lvl) - 1))) & 64'd511;
    return base + idx[fltw_pkg::PA_W-1:0] * 8;
  endfunction

  function automatic fltw_pkg::out_item_t walk_step(input fltw_pkg::in_item_t it);
    fltw_pkg::out_item_t r;
    logic [63:0]  ent;
    logic [63:0]  fmask;
    logic [63:0]  off;
    logic [63:0]  pa;
    int           w;
    r = '0;
    ent = it.read_data;
    w = int'(width_reg);
    if (w < int'(fltw_pkg::PAB_MIN)) w = int'(fltw_pkg::PAB_MIN);
    if (w > int'(fltw_pkg::PAB_MAX)) w = int'(fltw_pkg::PAB_MAX);
    fmask = ((64'd1 << w) - 64'd1) & ~64'hFFF;
    if (it.kind == fltw_pkg::IK_REQUEST) begin
      if ((it.virt_addr[63:47] != '0 && it.virt_addr[63:47] != fltw_pkg::HIGH_ALL_ONE) ||
          it.root_table == '0) begin
        pred_active = 1'b0;
        pred_level = fltw_pkg::LVL_NONE;
        r.result_kind = fltw_pkg::RK_DONE;
        r.status = fltw_pkg::ST_FAULT;
      end else begin
        pred_active = 1'b1;
        pred_level = fltw_pkg::LVL_4;
        pred_va = it.virt_addr[fltw_pkg::HVA_W-1:0];
        pred_perm = 2'b11;
        pred_nx = 1'b0;
        r.result_kind = fltw_pkg::RK_READ;
        r.read_addr = pte_address(it.root_table, fltw_pkg::LVL_4);
      end
    end else if (!pred_active) begin
      r.result_kind = fltw_pkg::RK_DONE;
      r.status = fltw_pkg::ST_IDLE_RESP;
    end else if (!ent[fltw_pkg::B_PRESENT]) begin
      pred_active = 1'b0;
      pred_level = fltw_pkg::LVL_NONE;
      r.result_kind = fltw_pkg::RK_DONE;
      r.status = fltw_pkg::ST_FAULT;
    end else begin
      pred_perm = pred_perm & {ent[fltw_pkg::B_USER], ent[fltw_pkg::B_WRITE]};
      pred_nx = pred_nx | ent[fltw_pkg::B_NX];
      if (pred_level == fltw_pkg::LVL_1 ||
          ((pred_level == fltw_pkg::LVL_2 || pred_level == fltw_pkg::LVL_3) &&
           ent[fltw_pkg::B_LARGE])) begin
        off = (64'd1 << (12 + 9 * (int'(pred_level) - 1))) - 64'd1;
        pa = (ent & fmask & ~off) | ({16'd0, pred_va} & off);
        r.result_kind = fltw_pkg::RK_DONE;
        r.status = fltw_pkg::ST_OK;
        r.phys_addr = pa[fltw_pkg::PA_W-1:0];
        r.perm_user = pred_perm[1];
        r.perm_write = pred_perm[0];
        r.no_exec = pred_nx;
        r.page_size = 2'(pred_level - fltw_pkg::LVL_1);
        pred_active = 1'b0;
        pred_level = fltw_pkg::LVL_NONE;
      end else begin
        pred_level = pred_level - 3'd1;
        pa = ent & fmask;
        r.result_kind = fltw_pkg::RK_READ;
        r.read_addr = pte_address(pa[fltw_pkg::PA_W-1:0], pred_level);
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] canon_va();
    logic [63:0] v;
    v = rand64();
    v[63:48] = {16{v[47]}};
    return v;
  endfunction

  function automatic logic [63:0] noncanon_va();
    logic [63:0] v;
    v = rand64();
    if (v[63:47] == '0 || v[63:47] == fltw_pkg::HIGH_ALL_ONE) v[50] = ~v[50];
    return v;
  endfunction

  function automatic logic [fltw_pkg::PA_W-1:0] rand_root();
    logic [63:0] v;
    v = rand64();
    // push some roots near the top so the entry address wraps
    if ($urandom_range(9) == 0) v[51:16] = '1;
    if (v[fltw_pkg::PA_W-1:0] == '0) v[12] = 1'b1;
    return v[fltw_pkg::PA_W-1:0];
  endfunction

  task automatic add_item(input logic k, input logic [63:0] va,
                          input logic [fltw_pkg::PA_W-1:0] root, input logic [63:0] data);
    fltw_pkg::in_item_t it;
    it.kind = k;
    it.virt_addr = va;
    it.root_table = root;
    it.read_data = data;
    walk_items.push_back(it);
    queued_count++;
  endtask

  // request followed by entries until the walk ends, or dropped early
  task automatic queue_walk();
    logic [63:0] e;
    int          lvl;
    add_item(fltw_pkg::IK_REQUEST, canon_va(), rand_root(), rand64());
    for (lvl = 4; lvl >= 1; lvl--) begin
      e = rand64();
      e[fltw_pkg::B_PRESENT] = ($urandom_range(9) != 0);
      e[fltw_pkg::B_LARGE] = ($urandom_range(3) == 0);
      e[fltw_pkg::B_USER] = ($urandom_range(3) != 0);
      e[fltw_pkg::B_WRITE] = ($urandom_range(3) != 0);
      e[fltw_pkg::B_NX] = ($urandom_range(3) == 0);
      add_item(fltw_pkg::IK_RESPONSE, rand64(), rand_root(), e);
      if (!e[fltw_pkg::B_PRESENT] || (e[fltw_pkg::B_LARGE] && (lvl == 2 || lvl == 3)) ||
          $urandom_range(15) == 0) break;
    end
  endtask

  task automatic queue_noise();
    case ($urandom_range(3))
      0: add_item(fltw_pkg::IK_REQUEST, noncanon_va(), rand_root(), rand64());
      1: add_item(fltw_pkg::IK_REQUEST, canon_va(), '0, rand64());
      2: add_item(fltw_pkg::IK_RESPONSE, rand64(), rand_root(), rand64());
      default: add_item(1'($urandom_range(1)), rand64(), rand_root(), rand64());
    endcase
  endtask

  task automatic queue_directed();
    // response with no walk in progress
    add_item(fltw_pkg::IK_RESPONSE, rand64(), rand_root(), rand64());
    // 4k walk at the top of the lower half, large bit ignored at levels 4 and 1
    add_item(fltw_pkg::IK_REQUEST, 64'h0000_7FFF_FFFF_FFFF, 52'h0_0000_0000_1000, 64'd0);
    add_item(fltw_pkg::IK_RESPONSE, 64'd0, '0, 64'h000F_FFFF_FFFF_F087);
    add_item(fltw_pkg::IK_RESPONSE, 64'd0, '0, 64'h0000_0000_0000_2007);
    add_item(fltw_pkg::IK_RESPONSE, 64'd0, '0, 64'h8000_0000_0000_3003);
    add_item(fltw_pkg::IK_RESPONSE, 64'd0, '0, 64'h7FFF_FFFF_FFFF_F085);
    // 1g page from the bottom of the upper half
    add_item(fltw_pkg::IK_REQUEST, 64'hFFFF_8000_0000_0000, 52'hF_FFFF_FFFF_F000, 64'd0);
    add_item(fltw_pkg::IK_RESPONSE, 64'd0, '0, 64'h0000_0001_2345_6007);
    add_item(fltw_pkg::IK_RESPONSE, 64'd0, '0, 64'h0000_00FF_C000_0087);
    // entry address wraps past the top, then a 2m page with every bit set
    add_item(fltw_pkg::IK_REQUEST, 64'hFFFF_FFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFF8, 64'd0);
    add_item(fltw_pkg::IK_RESPONSE, 64'd0, '0, 64'h0000_0000_0000_5007);
    add_item(fltw_pkg::IK_RESPONSE, 64'd0, '0, 64'h0000_0000_0000_6007);
    add_item(fltw_pkg::IK_RESPONSE, 64'd0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
    // non-canonical on both sides of the hole, and zero root
    add_item(fltw_pkg::IK_REQUEST, 64'h0000_8000_0000_0000, 52'h0_0000_0000_1000, 64'd0);
    add_item(fltw_pkg::IK_REQUEST, 64'hFFFF_7FFF_FFFF_FFFF, 52'h0_0000_0000_1000, 64'd0);
    add_item(fltw_pkg::IK_REQUEST, canon_va(), '0, 64'd0);
    // not present at the top level, then a response after the fault
    add_item(fltw_pkg::IK_REQUEST, canon_va(), rand_root(), 64'd0);
    add_item(fltw_pkg::IK_RESPONSE, 64'd0, '0, 64'hFFFF_FFFF_FFFF_FFFE);
    add_item(fltw_pkg::IK_RESPONSE, 64'd0, '0, 64'h0000_0000_0000_0007);
    // request while busy restarts, then not present one level down
    add_item(fltw_pkg::IK_REQUEST, canon_va(), rand_root(), 64'd0);
    add_item(fltw_pkg::IK_RESPONSE, 64'd0, '0, 64'h0000_0000_0000_8001);
    add_item(fltw_pkg::IK_REQUEST, 64'd0, 52'h0_0000_0000_0001, 64'd0);
    add_item(fltw_pkg::IK_RESPONSE, 64'd0, '0, 64'h0000_0000_0000_9005);
    add_item(fltw_pkg::IK_RESPONSE, 64'd0, '0, 64'h0000_0000_0000_A000);
  endtask

  task automatic write_width(input logic [fltw_pkg::PAB_W-1:0] w);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    width_reg = w;
  endtask

  task automatic width_write_random();
    write_width(fltw_pkg::PAB_W'($urandom_range(63)));
  endtask

  task automatic wait_drained();
    while (walk_items.size() != 0 || expected_walk_results.size() != 0) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);
  endtask

  // driver: one transaction per accepting edge
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_walk_results.push_back(walk_step(item));
        walk_items.delete(0);
      end
      if (walk_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        item <= walk_items[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_walk_results.size() == 0) begin
          $error("result transaction with nothing expected");
          error_count++;
        end else begin
          want = expected_walk_results.pop_front();
          if (result.result_kind !== want.result_kind) begin
            $error("result_kind expected %0h got %0h", want.result_kind, result.result_kind);
            error_count++;
          end
          if (result.read_addr !== want.read_addr) begin
            $error("read_addr expected %h got %h", want.read_addr, result.read_addr);
            error_count++;
          end
          if (result.status !== want.status) begin
            $error("status expected %0h got %0h", want.status, result.status);
            error_count++;
          end
          if (result.phys_addr !== want.phys_addr) begin
            $error("phys_addr expected %h got %h", want.phys_addr, result.phys_addr);
            error_count++;
          end
          if (result.perm_user !== want.perm_user) begin
            $error("perm_user expected %0h got %0h", want.perm_user, result.perm_user);
            error_count++;
          end
          if (result.perm_write !== want.perm_write) begin
            $error("perm_write expected %0h got %0h", want.perm_write, result.perm_write);
            error_count++;
          end
          if (result.no_exec !== want.no_exec) begin
            $error("no_exec expected %0h got %0h", want.no_exec, result.no_exec);
            error_count++;
          end
          if (result.page_size !== want.page_size) begin
            $error("page_size expected %0h got %0h", want.page_size, result.page_size);
            error_count++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("four_level_page_table_walker verification failed");
    $finish;
  end

  logic [fltw_pkg::PAB_W-1:0] width_plan [PHASE_COUNT] = '{6'd52, 6'd36, 6'd63, 6'd0,
                                                           6'd35, 6'd53, 6'd44, 6'd40};
  int send_plan [4] = '{0, 56, 0, 35};
  int recv_plan [4] = '{0, 0, 56, 35};

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p == PHASE_COUNT - 1) width_write_random();
      else write_width(width_plan[p]);
      // fill away from the clock edge the driver samples on
      @(negedge clk);
      send_idle_pct = send_plan[p % 4];
      recv_stall_pct = recv_plan[p % 4];
      if (p == 0) queue_directed();
      queued_count = 0;
      while (queued_count < PHASE_ITEMS) begin
        if ($urandom_range(99) < 80) queue_walk();
        else queue_noise();
      end
      wait_drained();
    end
    if (error_count == 0) begin
      $display("four_level_page_table_walker verification clean");
    end else begin
      $display("four_level_page_table_walker verification failed");
    end
    $finish;
  end

endmodule
